// ----- sv/ntc_tl_pkg.sv -----
package ntc_tl_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_TO_TEMP = 2'd1;
  localparam logic [1:0] MODE_TO_RES  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_LOWEST  = 2'd1;
  localparam logic [1:0] CFG_HIGHEST = 2'd2;
  localparam logic [1:0] CFG_STEP    = 2'd3;

  // Register reset values
  localparam logic [8:0]        RST_ENTRIES = 9'd2;
  localparam logic signed [9:0] RST_LOWEST  = 10'sd0;
  localparam logic signed [9:0] RST_HIGHEST = 10'sd1;
  localparam logic [7:0]        RST_STEP    = 8'd1;

  // Field widths
  localparam int RES_W   = 32;
  localparam int TEMP_W  = 16;
  localparam int SLOT_W  = 8;
  localparam int STEP_W  = 8;
  localparam int CFG_W   = 10;

  // Serial divider: dividend covers (rh - res) * step * 10 + d / 2
  localparam int DVD_W   = 44;
  localparam int DCNT_W  = 6;
  localparam int STEP10_W = 12;

  // Width of tdata buses
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  // Value times ten, kept to 16 bits
  function automatic logic [TEMP_W-1:0] times_ten(input logic [TEMP_W-1:0] v);
    logic [TEMP_W-1:0] s3;
    logic [TEMP_W-1:0] s1;
    s3 = v << 3;
    s1 = v << 1;
    return s3 + s1;
  endfunction

endpackage

// ----- sv/ntc_tl_ram.sv -----
module ntc_tl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ntc_table_temperature_lookup_core.sv -----
// Channel  | Dir | Signals                      | Contents (lowest bit first)
// in_      | in  | tvalid tready tdata tuser    | tdata: entry_index, resistance, temp_in
//          |     |                              | tuser: mode
// out_     | out | tvalid tready tdata tuser    | tdata: temp_tenths, resistance_out
//          |     |                              | tuser: ok
// cfg_     | in  | we index data                | entries_in_use, lowest/highest_temp, step
//
// One item at a time. Table write and unused kind: through S_OUT to the output register.
// Temperature to resistance: the 44-step serial divider, then a table read in S_RREV.
// Resistance to temperature: end checks, then a binary search with a read and a
// compare per probe on the registered-read table RAM, then the 44-step divider.
// Synchronous active-low reset clears control state and sets config defaults;
// the table holds no valid bits and reads as undefined until written. A stalled
// output holds its result while the next item is already accepted and worked on.
module ntc_table_temperature_lookup_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // entry_index [7:0], resistance [39:8], temp_in [55:40]
  input  logic [ntc_tl_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode [1:0]
  input  logic [1:0]                            in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // temp_tenths [15:0], resistance_out [47:16]
  output logic [ntc_tl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // ok [0]
  output logic [0:0]                            out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [ntc_tl_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = NW + 1;
  localparam int PW = AW + ntc_tl_pkg::STEP_W;
  localparam int RW = ntc_tl_pkg::RES_W;
  localparam int TW = ntc_tl_pkg::TEMP_W;
  localparam int DW = ntc_tl_pkg::DVD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RMAX, S_RMIN, S_SEARCH, S_CMP, S_RH, S_RL,
    S_MUL, S_ADD, S_DIV, S_ETEN, S_TEN, S_RREV, S_OUT
  } state_t;

  // Configuration registers
  logic [8:0]        cfg_entries_r;
  logic signed [9:0] cfg_lowest_r;
  logic signed [9:0] cfg_highest_r;
  logic [7:0]        cfg_step_r;

  // Working registers
  state_t                state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [RW-1:0]         res_q_r, res_q_nxt;
  logic [RW-1:0]         rmax_r, rmax_nxt;
  logic [RW-1:0]         rh_r, rh_nxt;
  logic signed [LW-1:0]  lo_r, lo_nxt;
  logic signed [LW-1:0]  hi_r, hi_nxt;
  logic signed [LW-1:0]  mid_r, mid_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [TW-1:0]         prod_r, prod_nxt;
  logic [TW-1:0]         frac_r, frac_nxt;
  logic [RW-1:0]         a_r, a_nxt;
  logic [RW-1:0]         dsr_r, dsr_nxt;
  logic [DW-1:0]         dvd_r, dvd_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [ntc_tl_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                  rs_ok_r, rs_ok_nxt;
  logic [TW-1:0]         rs_tenths_r, rs_tenths_nxt;
  logic [RW-1:0]         rs_rout_r, rs_rout_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [TW-1:0]         out_tenths_r, out_tenths_nxt;
  logic [RW-1:0]         out_rout_r, out_rout_nxt;

  // Table RAM controls
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // Input fields
  logic [7:0]           in_slot;
  logic [RW-1:0]        in_res;
  logic signed [TW-1:0] in_temp;
  assign in_slot = in_tdata[7:0];
  assign in_res  = in_tdata[39:8];
  assign in_temp = in_tdata[55:40];

  // Derived configuration
  logic [NW-1:0]     n_use;
  logic [NW-1:0]     n_m1;
  logic signed [LW-1:0] n_s;
  logic [7:0]        eff_step;
  logic [ntc_tl_pkg::STEP10_W-1:0] step10;
  assign n_use    = (32'(cfg_entries_r) > TABLE_DEPTH) ? NW'(TABLE_DEPTH)
                                                        : NW'(cfg_entries_r);
  assign n_m1     = n_use - NW'(1);
  assign n_s      = $signed({1'b0, n_use});
  assign eff_step = (cfg_step_r == 8'd0) ? 8'd1 : cfg_step_r;
  assign step10   = ntc_tl_pkg::STEP10_W'({eff_step, 3'b000})
                  + ntc_tl_pkg::STEP10_W'({eff_step, 1'b0});

  // Reverse lookup range check
  logic signed [TW:0] t17;
  logic signed [TW:0] lo17;
  logic signed [TW:0] hi17;
  logic [TW:0]        tdiff;
  assign t17   = (TW+1)'(in_temp);
  assign lo17  = (TW+1)'(cfg_lowest_r);
  assign hi17  = (TW+1)'(cfg_highest_r);
  assign tdiff = t17 - lo17;

  // Search midpoint
  logic signed [LW-1:0] span;
  logic signed [LW-1:0] mid_c;
  assign span  = hi_r - lo_r;
  assign mid_c = lo_r + (span >>> 1);

  // Divider step
  logic [RW:0] rem_sh;
  logic [RW:0] rem_sub;
  logic        div_ge;
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign div_ge  = rem_sh >= {1'b0, dsr_r};

  // Interpolation product and entry offset product
  logic [DW-1:0] mul_p;
  logic [PW-1:0] idx_p;
  logic [TW-1:0] base16;
  assign mul_p  = DW'(a_r) * DW'(step10);
  assign idx_p  = PW'(idx_r) * PW'(eff_step);
  assign base16 = TW'(cfg_lowest_r) + prod_r;

  assign in_tready = (state_r == S_IDLE);

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    res_q_nxt      = res_q_r;
    rmax_nxt       = rmax_r;
    rh_nxt         = rh_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    idx_nxt        = idx_r;
    prod_nxt       = prod_r;
    frac_nxt       = frac_r;
    a_nxt          = a_r;
    dsr_nxt        = dsr_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    rs_ok_nxt      = rs_ok_r;
    rs_tenths_nxt  = rs_tenths_r;
    rs_rout_nxt    = rs_rout_r;
    out_valid_nxt  = out_valid_r;
    out_ok_nxt     = out_ok_r;
    out_tenths_nxt = out_tenths_r;
    out_rout_nxt   = out_rout_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(in_slot);
    ram_wdata      = in_res;
    ram_raddr      = '0;

    // Output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt      = in_tuser;
          res_q_nxt     = in_res;
          rs_ok_nxt     = 1'b0;
          rs_tenths_nxt = '0;
          rs_rout_nxt   = '0;
          state_nxt     = S_OUT;
          case (in_tuser)
            ntc_tl_pkg::MODE_WRITE: begin
              if (32'(in_slot) < TABLE_DEPTH) begin
                ram_we    = 1'b1;
                rs_ok_nxt = 1'b1;
              end
            end
            ntc_tl_pkg::MODE_TO_TEMP: begin
              if (n_use >= NW'(2)) begin
                ram_raddr = '0;
                state_nxt = S_RMAX;
              end
            end
            ntc_tl_pkg::MODE_TO_RES: begin
              if (!(t17 < lo17 || t17 > hi17)) begin
                dvd_nxt   = DW'(tdiff);
                dsr_nxt   = RW'(eff_step);
                rem_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = S_DIV;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // Entry 0 arrives; fetch the last entry
      S_RMAX: begin
        rmax_nxt  = ram_rdata;
        ram_raddr = n_m1[AW-1:0];
        state_nxt = S_RMIN;
      end

      // End checks, then start the search
      S_RMIN: begin
        if (res_q_r > rmax_r || res_q_r < ram_rdata) begin
          state_nxt = S_OUT;
        end else if (res_q_r == rmax_r) begin
          rs_ok_nxt     = 1'b1;
          rs_tenths_nxt = ntc_tl_pkg::times_ten(TW'(cfg_lowest_r));
          state_nxt     = S_OUT;
        end else if (res_q_r == ram_rdata) begin
          rs_ok_nxt     = 1'b1;
          rs_tenths_nxt = ntc_tl_pkg::times_ten(TW'(cfg_highest_r));
          state_nxt     = S_OUT;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = n_s - LW'(1);
          state_nxt = S_SEARCH;
        end
      end

      // Issue a probe or leave with the bracketing pair
      S_SEARCH: begin
        if (lo_r <= hi_r) begin
          ram_raddr = mid_c[AW-1:0];
          mid_nxt   = mid_c;
          state_nxt = S_CMP;
        end else if (hi_r < 0 || hi_r > n_s - LW'(2)) begin
          state_nxt = S_OUT;
        end else begin
          ram_raddr = hi_r[AW-1:0];
          state_nxt = S_RH;
        end
      end

      S_CMP: begin
        if (ram_rdata == res_q_r) begin
          idx_nxt   = mid_r[AW-1:0];
          frac_nxt  = '0;
          state_nxt = S_ETEN;
        end else begin
          if (ram_rdata > res_q_r) begin
            lo_nxt = mid_r + LW'(1);
          end else begin
            hi_nxt = mid_r - LW'(1);
          end
          state_nxt = S_SEARCH;
        end
      end

      S_RH: begin
        rh_nxt    = ram_rdata;
        ram_raddr = AW'(hi_r + LW'(1));
        state_nxt = S_RL;
      end

      // Lower entry: check the pair falls, set up the fraction
      S_RL: begin
        if (rh_r <= ram_rdata) begin
          state_nxt = S_OUT;
        end else begin
          a_nxt     = rh_r - res_q_r;
          dsr_nxt   = rh_r - ram_rdata;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        dvd_nxt   = mul_p;
        state_nxt = S_ADD;
      end

      // Rounding term, then divide
      S_ADD: begin
        dvd_nxt   = dvd_r + DW'(dsr_r >> 1);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end

      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        if (cnt_r == ntc_tl_pkg::DCNT_W'(DW)) begin
          if (mode_r == ntc_tl_pkg::MODE_TO_TEMP) begin
            frac_nxt  = dvd_r[TW-1:0];
            idx_nxt   = hi_r[AW-1:0];
            state_nxt = S_ETEN;
          end else if (dvd_r >= DW'(n_use)) begin
            state_nxt = S_OUT;
          end else begin
            ram_raddr = dvd_r[AW-1:0];
            state_nxt = S_RREV;
          end
        end else begin
          rem_nxt = div_ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
          dvd_nxt = {dvd_r[DW-2:0], div_ge};
          cnt_nxt = cnt_r + ntc_tl_pkg::DCNT_W'(1);
        end
      end

      S_ETEN: begin
        prod_nxt  = TW'(idx_p);
        state_nxt = S_TEN;
      end

      S_TEN: begin
        rs_ok_nxt     = 1'b1;
        rs_tenths_nxt = ntc_tl_pkg::times_ten(base16) + frac_r;
        state_nxt     = S_OUT;
      end

      S_RREV: begin
        rs_ok_nxt   = 1'b1;
        rs_rout_nxt = ram_rdata;
        state_nxt   = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_ok_nxt     = rs_ok_r;
          out_tenths_nxt = rs_tenths_r;
          out_rout_nxt   = rs_rout_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    res_q_r      <= res_q_nxt;
    rmax_r       <= rmax_nxt;
    rh_r         <= rh_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    idx_r        <= idx_nxt;
    prod_r       <= prod_nxt;
    frac_r       <= frac_nxt;
    a_r          <= a_nxt;
    dsr_r        <= dsr_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    rs_ok_r      <= rs_ok_nxt;
    rs_tenths_r  <= rs_tenths_nxt;
    rs_rout_r    <= rs_rout_nxt;
    out_ok_r     <= out_ok_nxt;
    out_tenths_r <= out_tenths_nxt;
    out_rout_r   <= out_rout_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= ntc_tl_pkg::RST_ENTRIES;
      cfg_lowest_r  <= ntc_tl_pkg::RST_LOWEST;
      cfg_highest_r <= ntc_tl_pkg::RST_HIGHEST;
      cfg_step_r    <= ntc_tl_pkg::RST_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        ntc_tl_pkg::CFG_ENTRIES: cfg_entries_r <= cfg_data[8:0];
        ntc_tl_pkg::CFG_LOWEST:  cfg_lowest_r  <= cfg_data[9:0];
        ntc_tl_pkg::CFG_HIGHEST: cfg_highest_r <= cfg_data[9:0];
        ntc_tl_pkg::CFG_STEP:    cfg_step_r    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Resistance table
  ntc_tl_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_rout_r, out_tenths_r};

endmodule
